### hdl/bscf_pkg.sv
// ----------------------------------------------------------------------------
// bscf_pkg
// Shared types, sizes and word helpers for the bitmap set/clear/find engine.
// ----------------------------------------------------------------------------
package bscf_pkg;

  localparam int WORD_BITS = 32;
  localparam int NUM_WORDS = 64;

  localparam int WA_W       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int CAP_BITS   = NUM_WORDS * WORD_BITS;
  localparam int LAST_WORD  = NUM_WORDS - 1;

  // find-next stops at the largest index the result field can hold
  localparam int INDEX_LIMIT  = 2048;
  localparam int SEARCH_LIMIT = (CAP_BITS < INDEX_LIMIT) ? CAP_BITS : INDEX_LIMIT;
  localparam int SEARCH_LAST  = SEARCH_LIMIT / WORD_BITS - 1;

  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 24;
  localparam int CNT_W       = 12;

  typedef enum logic [2:0] {
    ACT_SET_BIT     = 3'd0,
    ACT_CLEAR_BIT   = 3'd1,
    ACT_SET_RANGE   = 3'd2,
    ACT_CLEAR_RANGE = 3'd3,
    ACT_FIND_NEXT   = 3'd4,
    ACT_COUNT       = 3'd5,
    ACT_CLEAR_ALL   = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_WALK = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  // population count, adder tree on fixed masks
  function automatic logic [5:0] pop32(input logic [31:0] x);
    logic [31:0] v;
    v = (x & 32'h5555_5555) + ((x >> 1) & 32'h5555_5555);
    v = (v & 32'h3333_3333) + ((v >> 2) & 32'h3333_3333);
    v = (v & 32'h0f0f_0f0f) + ((v >> 4) & 32'h0f0f_0f0f);
    v = (v & 32'h00ff_00ff) + ((v >> 8) & 32'h00ff_00ff);
    v = (v & 32'h0000_ffff) + (v >> 16);
    return v[5:0];
  endfunction

  // position of the lowest set bit of a nonzero word
  function automatic logic [4:0] low_one(input logic [31:0] x);
    logic [31:0] v;
    logic [31:0] m;
    logic [4:0]  pos;
    v   = x;
    pos = 5'd31;
    m = v & 32'h0000_ffff; if (m != '0) begin v = m; pos = pos - 5'd16; end
    m = v & 32'h00ff_00ff; if (m != '0) begin v = m; pos = pos - 5'd8;  end
    m = v & 32'h0f0f_0f0f; if (m != '0) begin v = m; pos = pos - 5'd4;  end
    m = v & 32'h3333_3333; if (m != '0) begin v = m; pos = pos - 5'd2;  end
    m = v & 32'h5555_5555; if (m != '0) begin pos = pos - 5'd1; end
    return pos;
  endfunction

endpackage

### hdl/bitmap_set_clear_find_engine.sv
// ----------------------------------------------------------------------------
// bitmap_set_clear_find_engine
// Word-organized bitmap with bit/range set and clear, find-next and count.
// ----------------------------------------------------------------------------
// Flow: one request at a time; in_tready is high only while idle. A walk
//   reads one word per cycle from the single read port of the word memory;
//   set and clear write each word back after it is read. A count walks every
//   word. Requests that touch no word (clear all, no-op) go straight to the
//   result, which is held while out_tready is low.
// Reset: synchronous, active low. Per-word valid flags are all cleared
//   together, so the map reads all zeros at once; no clearing sweep.
module bitmap_set_clear_find_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata, lowest bit up: low_bit[10:0], high_bit[21:11], after_bit[33:22]
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [bscf_pkg::IN_TDATA_W-1:0]   in_tdata,
  // in_tuser: action[2:0]
  input  logic [bscf_pkg::IN_TUSER_W-1:0]   in_tuser,
  // out_tdata, lowest bit up: found[0], bit_index[11:1], set_count[23:12]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bscf_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import bscf_pkg::*;

  localparam logic [WORD_BITS-1:0] ONES = '1;

  // word store plus one valid flag per word (invalid reads as zero)
  logic [WORD_BITS-1:0] bit_words_mem [NUM_WORDS];
  logic [WORD_BITS-1:0] mem_q_r;
  logic [NUM_WORDS-1:0] word_vld_r;

  state_t   state_r, state_nxt;
  action_t  op_r, op_nxt;
  logic [WA_W-1:0] first_r, first_nxt;
  logic [WA_W-1:0] last_r, last_nxt;
  logic [4:0]      lo_off_r, lo_off_nxt;
  logic [4:0]      hi_off_r, hi_off_nxt;

  // read issue pointer and data-stage tag
  logic [WA_W-1:0] rd_w_r, rd_w_nxt;
  logic            issued_all_r, issued_all_nxt;
  logic            pend_v_r, pend_v_nxt;
  logic [WA_W-1:0] pend_w_r, pend_w_nxt;

  // result being built
  logic             res_found_r, res_found_nxt;
  logic [10:0]      res_idx_r, res_idx_nxt;
  logic [CNT_W-1:0] res_cnt_r, res_cnt_nxt;

  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic                 rd_en;
  logic                 wr_en;
  logic [WORD_BITS-1:0] wr_data;
  logic                 clear_all;

  // input fields
  logic [10:0] lo_in, hi_in;
  logic [11:0] after_in, start_in;
  logic        lo_ok, hi_over;

  // data-stage helpers
  logic [WORD_BITS-1:0] word_q, span, fv;
  logic [4:0]           a_off, b_off;
  logic [CNT_W:0]       cnt_sum;
  logic                 at_first, at_last;

  assign lo_in    = in_tdata[10:0];
  assign hi_in    = in_tdata[21:11];
  assign after_in = in_tdata[33:22];
  // a negative start (-1 or below) searches from bit zero
  assign start_in = after_in[11] ? 12'd0 : after_in + 12'd1;
  assign lo_ok    = (lo_in < CAP_BITS);
  assign hi_over  = (hi_in >= CAP_BITS);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  assign at_first = (pend_w_r == first_r);
  assign at_last  = (pend_w_r == last_r);
  assign word_q   = word_vld_r[pend_w_r] ? mem_q_r : '0;
  assign a_off    = at_first ? lo_off_r : 5'd0;
  assign b_off    = at_last ? hi_off_r : 5'd31;
  assign span     = (ONES << a_off) & (ONES >> (5'd31 - b_off));
  assign fv       = at_first ? (word_q & (ONES << lo_off_r)) : word_q;
  assign cnt_sum  = {1'b0, res_cnt_r} + (CNT_W + 1)'(pop32(word_q));

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    first_nxt      = first_r;
    last_nxt       = last_r;
    lo_off_nxt     = lo_off_r;
    hi_off_nxt     = hi_off_r;
    rd_w_nxt       = rd_w_r;
    issued_all_nxt = issued_all_r;
    pend_v_nxt     = 1'b0;
    pend_w_nxt     = rd_w_r;
    res_found_nxt  = res_found_r;
    res_idx_nxt    = res_idx_r;
    res_cnt_nxt    = res_cnt_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_tdata_nxt  = out_tdata_r;
    rd_en          = 1'b0;
    wr_en          = 1'b0;
    wr_data        = word_q;
    clear_all      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          logic walk;
          walk           = 1'b0;
          op_nxt         = action_t'(in_tuser);
          res_found_nxt  = 1'b0;
          res_idx_nxt    = '0;
          res_cnt_nxt    = '0;
          issued_all_nxt = 1'b0;
          first_nxt      = WA_W'(lo_in >> 5);
          last_nxt       = WA_W'(lo_in >> 5);
          lo_off_nxt     = lo_in[4:0];
          hi_off_nxt     = lo_in[4:0];
          case (action_t'(in_tuser))
            ACT_SET_BIT, ACT_CLEAR_BIT: begin
              walk = lo_ok;
            end
            ACT_SET_RANGE, ACT_CLEAR_RANGE: begin
              // reversed or out-of-capacity ranges change nothing
              walk       = lo_ok && (lo_in <= hi_in);
              last_nxt   = hi_over ? WA_W'(LAST_WORD) : WA_W'(hi_in >> 5);
              hi_off_nxt = hi_over ? 5'd31 : hi_in[4:0];
            end
            ACT_FIND_NEXT: begin
              walk       = (start_in < SEARCH_LIMIT);
              first_nxt  = WA_W'(start_in >> 5);
              last_nxt   = WA_W'(SEARCH_LAST);
              lo_off_nxt = start_in[4:0];
              hi_off_nxt = 5'd31;
            end
            ACT_COUNT: begin
              walk      = 1'b1;
              first_nxt = '0;
              last_nxt  = WA_W'(LAST_WORD);
            end
            ACT_CLEAR_ALL: begin
              clear_all = 1'b1;
            end
            default: begin
            end
          endcase
          rd_w_nxt  = first_nxt;
          state_nxt = walk ? ST_WALK : ST_DONE;
        end
      end

      ST_WALK: begin
        // issue stage: one word read per cycle
        if (!issued_all_r) begin
          rd_en      = 1'b1;
          pend_v_nxt = 1'b1;
          if (rd_w_r == last_r) begin
            issued_all_nxt = 1'b1;
          end else begin
            rd_w_nxt = rd_w_r + 1'b1;
          end
        end
        // data stage: modify, write back, test or accumulate
        if (pend_v_r) begin
          case (op_r)
            ACT_SET_BIT, ACT_SET_RANGE: begin
              wr_en   = 1'b1;
              wr_data = word_q | span;
              if (at_last) state_nxt = ST_DONE;
            end
            ACT_CLEAR_BIT, ACT_CLEAR_RANGE: begin
              wr_en   = 1'b1;
              wr_data = word_q & ~span;
              if (at_last) state_nxt = ST_DONE;
            end
            ACT_FIND_NEXT: begin
              if (fv != '0) begin
                res_found_nxt = 1'b1;
                res_idx_nxt   = 11'({pend_w_r, low_one(fv)});
                state_nxt     = ST_DONE;
              end else if (at_last) begin
                state_nxt = ST_DONE;
              end
            end
            ACT_COUNT: begin
              res_cnt_nxt = cnt_sum[CNT_W] ? '1 : cnt_sum[CNT_W-1:0];
              if (at_last) state_nxt = ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
          // a read still in flight after an early stop is dropped
          if (state_nxt == ST_DONE) pend_v_nxt = 1'b0;
        end
      end

      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {res_cnt_r, res_idx_r, res_found_r};
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      issued_all_r <= 1'b0;
      pend_v_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
      word_vld_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      issued_all_r <= issued_all_nxt;
      pend_v_r     <= pend_v_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (clear_all) begin
        word_vld_r <= '0;
      end else if (wr_en) begin
        word_vld_r[pend_w_r] <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    first_r     <= first_nxt;
    last_r      <= last_nxt;
    lo_off_r    <= lo_off_nxt;
    hi_off_r    <= hi_off_nxt;
    rd_w_r      <= rd_w_nxt;
    pend_w_r    <= pend_w_nxt;
    res_found_r <= res_found_nxt;
    res_idx_r   <= res_idx_nxt;
    res_cnt_r   <= res_cnt_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  // word memory: one read, one write per cycle, never the same word
  always_ff @(posedge clk) begin
    if (rd_en) mem_q_r <= bit_words_mem[rd_w_r];
    if (wr_en) bit_words_mem[pend_w_r] <= wr_data;
  end

endmodule

### hdl/bscf_checker.sv
// ----------------------------------------------------------------------------
// bscf_checker
// Port-level checks for the bitmap engine, bound onto the top level.
// ----------------------------------------------------------------------------
module bscf_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [bscf_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  // no result right out of reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // not found means index zero
  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[11:1] == 11'd0)
    else $error("index without found flag");

  // a result with the found flag set carries no count
  a_find_no_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[23:12] == 12'd0)
    else $error("found flag with nonzero count");

  // a request just taken cannot already have its result presented
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("result one cycle after request");

endmodule

bind bitmap_set_clear_find_engine bscf_checker u_bscf_checker (.*);

### tb/sv/tb_bitmap_set_clear_find_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmap_set_clear_find_engine
// Self-checking bench for the bitmap engine. A directed table covers the edge
// cases, then about 800 random requests run in four flow-control phases. A
// behavioral copy of the bitmap follows every request, and each returned
// transaction is compared field by field with the oldest owed answer.
// ----------------------------------------------------------------------------
module tb_bitmap_set_clear_find_engine;
  import bscf_pkg::*;

  // sizes of the predictor's own bitmap copy
  localparam int WB        = bscf_pkg::WORD_BITS;
  localparam int NW        = bscf_pkg::NUM_WORDS;
  localparam int CAP       = NW * WB;
  // find-next never reports past the largest index bit_index can carry
  localparam int REACH     = (CAP < 2048) ? CAP : 2048;

  localparam logic [2:0]  ACT_UNUSED = 3'd7;   // spare code: no-op, zero result
  localparam logic [11:0] FROM_START = 12'hFFF; // after_bit = -1
  localparam logic [11:0] MOST_NEG   = 12'h800; // after_bit = -2048

  localparam int ITEMS_PER_PHASE = 200;
  localparam int HOLD_CYCLES     = 400;  // long receiver hold-off
  localparam int DRAIN_CYCLES    = 80;   // wait for stray results after the drain
  localparam int CYCLE_LIMIT     = 400000;

  typedef struct packed {
    logic [2:0]  action;
    logic [10:0] lo;
    logic [10:0] hi;
    logic [11:0] after;
  } request_t;

  // laid out MSB first so it maps straight onto out_tdata
  typedef struct packed {
    logic [11:0] set_count;
    logic [10:0] bit_index;
    logic        found;
  } answer_t;

  typedef struct {
    request_t req;
    bit       typed;     // expected answer written in the table
    answer_t  ans;
  } table_row_t;

  logic clk;
  logic rst_n;

  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_TDATA_W-1:0]    in_tdata;
  logic [IN_TUSER_W-1:0]    in_tuser;
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_TDATA_W-1:0]   out_tdata;

  // predictor state and the queue of answers still owed by the block
  logic [WB-1:0] map_words [NW];
  answer_t       owed_answers [$];
  table_row_t    dir_rows [$];

  int  err_count;
  int  send_idle_pct;
  int  recv_stall_pct;
  logic hold_off;
  int  cycles;
  event hold_kick;

  bitmap_set_clear_find_engine uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor: bit-serial model of the map, one request at a time.
  // --------------------------------------------------------------------------
  function automatic answer_t bitmap_apply(input request_t r);
    answer_t res;
    int      b;
    int      start;
    int      total;
    res = '0;
    case (r.action)
      ACT_SET_BIT: begin
        if (r.lo < CAP) map_words[r.lo / WB][r.lo % WB] = 1'b1;
      end
      ACT_CLEAR_BIT: begin
        if (r.lo < CAP) map_words[r.lo / WB][r.lo % WB] = 1'b0;
      end
      ACT_SET_RANGE, ACT_CLEAR_RANGE: begin
        // reversed range runs zero times; top end clipped to capacity
        for (b = r.lo; b <= r.hi && b < CAP; b++)
          map_words[b / WB][b % WB] = (r.action == ACT_SET_RANGE);
      end
      ACT_FIND_NEXT: begin
        // any negative start means search from bit zero
        start = r.after[11] ? 0 : int'(r.after) + 1;
        for (b = start; b < REACH && !res.found; b++) begin
          if (map_words[b / WB][b % WB]) begin
            res.found     = 1'b1;
            res.bit_index = 11'(b);
          end
        end
      end
      ACT_COUNT: begin
        total = 0;
        for (b = 0; b < NW; b++) total += $countones(map_words[b]);
        res.set_count = (total > 4095) ? 12'd4095 : 12'(total);
      end
      ACT_CLEAR_ALL: begin
        for (b = 0; b < NW; b++) map_words[b] = '0;
      end
      default: ;
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: optional idle gap, then hold valid until the transaction is taken.
  // The expected answer is queued at the accepting edge.
  // --------------------------------------------------------------------------
  task automatic send_request(input request_t r, input bit typed, input answer_t ans);
    answer_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, r.after, r.hi, r.lo};
    in_tuser  <= r.action;
    do @(posedge clk); while (!in_tready);
    pred = bitmap_apply(r);
    owed_answers = {owed_answers, (typed ? ans : pred)};
  endtask

  task automatic add_row(input logic [2:0] act, input int lo, input int hi,
                         input logic [11:0] after, input bit typed,
                         input bit found, input int idx, input int cnt);
    table_row_t row;
    row.req.action    = act;
    row.req.lo        = 11'(lo);
    row.req.hi        = 11'(hi);
    row.req.after     = after;
    row.typed         = typed;
    row.ans.found     = found;
    row.ans.bit_index = 11'(idx);
    row.ans.set_count = 12'(cnt);
    dir_rows = {dir_rows, row};
  endtask

  // mostly short ranges so the walks stay cheap; a quarter fully random
  function automatic request_t random_request();
    request_t r;
    int       pick;
    int       top;
    pick = $urandom_range(99);
    if      (pick < 18) r.action = ACT_SET_BIT;
    else if (pick < 30) r.action = ACT_CLEAR_BIT;
    else if (pick < 46) r.action = ACT_SET_RANGE;
    else if (pick < 58) r.action = ACT_CLEAR_RANGE;
    else if (pick < 80) r.action = ACT_FIND_NEXT;
    else if (pick < 92) r.action = ACT_COUNT;
    else if (pick < 96) r.action = ACT_CLEAR_ALL;
    else                r.action = ACT_UNUSED;
    r.lo = 11'($urandom_range(2047));
    if ($urandom_range(3) == 0) begin
      r.hi = 11'($urandom_range(2047));
    end else begin
      top  = int'(r.lo) + $urandom_range(70);
      r.hi = (top > 2047) ? 11'd2047 : 11'(top);
    end
    case ($urandom_range(9))
      0:       r.after = FROM_START;
      1:       r.after = {1'b1, 11'($urandom_range(2047))};
      default: r.after = {1'b0, 11'($urandom_range(2047))};
    endcase
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Result side: compare each accepted transaction, then pick the next
  // ready level (held low during the pressure stretch).
  // --------------------------------------------------------------------------
  function automatic void check_answer(input answer_t got);
    answer_t want;
    if (owed_answers.size() == 0) begin
      $display("%0t: unexpected result %h, nothing outstanding", $time, got);
      err_count++;
    end else begin
      want = owed_answers.pop_front();
      if (got.found !== want.found) begin
        $display("%0t: found mismatch, expected %0d, actual %0d",
                 $time, want.found, got.found);
        err_count++;
      end
      if (got.bit_index !== want.bit_index) begin
        $display("%0t: bit_index mismatch, expected %0d, actual %0d",
                 $time, want.bit_index, got.bit_index);
        err_count++;
      end
      if (got.set_count !== want.set_count) begin
        $display("%0t: set_count mismatch, expected %0d, actual %0d",
                 $time, want.set_count, got.set_count);
        err_count++;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_answer(answer_t'(out_tdata));
      if (hold_off) out_tready <= 1'b0;
      else          out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long hold-off on the result side, counted here on its own
  initial begin
    hold_off = 1'b0;
    @(hold_kick);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout, %0d results outstanding", $time, owed_answers.size());
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int       i;
    int       ph;
    request_t r;
    answer_t  none;

    none           = '0;
    err_count      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    for (i = 0; i < NW; i++) map_words[i] = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty map, extreme indices, reversed and full ranges,
    // negative search start, search past the top, spare code, clear all
    add_row(ACT_COUNT,       0,    0,    FROM_START, 1, 0, 0,    0);
    add_row(ACT_FIND_NEXT,   0,    0,    FROM_START, 1, 0, 0,    0);
    add_row(ACT_SET_BIT,     0,    0,    12'd0,      1, 0, 0,    0);
    add_row(ACT_SET_BIT,     2047, 2047, 12'd0,      1, 0, 0,    0);
    add_row(ACT_FIND_NEXT,   0,    0,    FROM_START, 1, 1, 0,    0);
    add_row(ACT_FIND_NEXT,   0,    0,    12'd0,      1, 1, 2047, 0);
    add_row(ACT_FIND_NEXT,   0,    0,    12'd2047,   1, 0, 0,    0);
    add_row(ACT_COUNT,       0,    0,    12'd0,      1, 0, 0,    2);
    add_row(ACT_SET_RANGE,   100,  50,   12'd0,      1, 0, 0,    0);
    add_row(ACT_COUNT,       0,    0,    12'd0,      1, 0, 0,    2);
    add_row(ACT_SET_RANGE,   0,    2047, 12'd0,      1, 0, 0,    0);
    add_row(ACT_COUNT,       0,    0,    12'd0,      1, 0, 0,    2048);
    add_row(ACT_CLEAR_RANGE, 1,    2046, 12'd0,      1, 0, 0,    0);
    add_row(ACT_COUNT,       0,    0,    12'd0,      1, 0, 0,    2);
    add_row(ACT_CLEAR_BIT,   0,    0,    12'd0,      1, 0, 0,    0);
    add_row(ACT_FIND_NEXT,   2047, 2047, MOST_NEG,   1, 1, 2047, 0);
    add_row(ACT_UNUSED,      2047, 2047, 12'hFFF,    1, 0, 0,    0);
    add_row(ACT_SET_RANGE,   31,   32,   12'd0,      0, 0, 0,    0);
    add_row(ACT_FIND_NEXT,   0,    0,    12'd30,     0, 0, 0,    0);
    add_row(ACT_SET_RANGE,   5,    5,    12'd0,      0, 0, 0,    0);
    add_row(ACT_CLEAR_ALL,   0,    0,    12'd0,      1, 0, 0,    0);
    add_row(ACT_COUNT,       0,    0,    12'd0,      1, 0, 0,    0);
    add_row(ACT_SET_RANGE,   0,    31,   12'd0,      0, 0, 0,    0);
    add_row(ACT_SET_RANGE,   2016, 2047, 12'd0,      0, 0, 0,    0);
    add_row(ACT_COUNT,       0,    0,    12'd0,      0, 0, 0,    0);

    foreach (dir_rows[k]) send_request(dir_rows[k].req, dir_rows[k].typed, dir_rows[k].ans);

    // random: no idling (with the long hold-off up front), sender idle,
    // receiver stalling, then both
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  -> hold_kick; end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        r = random_request();
        send_request(r, 1'b0, none);
      end
    end
    in_tvalid <= 1'b0;

    // drain, then give any stray result time to show up
    while (owed_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### bitmap_set_clear_find_engine.f
hdl/bscf_pkg.sv
hdl/bitmap_set_clear_find_engine.sv
hdl/bscf_checker.sv
tb/sv/tb_bitmap_set_clear_find_engine.sv
